// File: sv/core_local_timer_interruptor_assert.svh
// ----------------------------------------------------------------------------
// Core-local timer interruptor: assertion macros
// Implication and next-cycle forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CORE_LOCAL_TIMER_INTERRUPTOR_ASSERT_SVH
`define CORE_LOCAL_TIMER_INTERRUPTOR_ASSERT_SVH

// same-cycle implication
`define CLINT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clint assertion failed");

// next-cycle implication
`define CLINT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clint assertion failed");

`endif

// File: sv/clint_pkg.sv
// ----------------------------------------------------------------------------
// Core-local timer interruptor package
// Operation and target codes, address map, decoded command and helpers.
// ----------------------------------------------------------------------------
package clint_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TGT_SOFT = 2'd0,
    TGT_CMP  = 2'd1,
    TGT_TIME = 2'd2,
    TGT_NONE = 2'd3
  } target_t;

  localparam logic [15:0] SOFT_BASE = 16'h0000;
  localparam int          SOFT_STEP = 4;
  localparam logic [15:0] CMP_BASE  = 16'h4000;
  localparam int          CMP_STEP  = 8;
  localparam logic [15:0] TIME_ADDR = 16'hBFF8;

  localparam int HART_IDX_W  = 4;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 72;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    op_t                   op;
    target_t               target;
    logic                  err;
    logic                  wide;
    logic                  hi;
    logic [HART_IDX_W-1:0] hart;
    logic [63:0]           data;
  } cmd_t;

  function automatic logic [63:0] half_read(input logic [63:0] val, input logic wide,
                                            input logic hi);
    logic [63:0] res;
    if (wide) begin
      res = val;
    end else if (hi) begin
      res = {32'd0, val[63:32]};
    end else begin
      res = {32'd0, val[31:0]};
    end
    return res;
  endfunction

  function automatic logic [63:0] half_merge(input logic [63:0] old, input logic [63:0] data,
                                             input logic wide, input logic hi);
    logic [63:0] res;
    if (wide) begin
      res = data;
    end else if (hi) begin
      res = {data[31:0], old[31:0]};
    end else begin
      res = {old[63:32], data[31:0]};
    end
    return res;
  endfunction

endpackage

// File: sv/core_local_timer_interruptor.sv
// ----------------------------------------------------------------------------
// Core-local timer interruptor
// Per-hart software interrupt bits, per-hart timer compares and a 64-bit time
// counter behind a streaming register-access port.
// ----------------------------------------------------------------------------
// One beat is taken per cycle unless input is held, and each gives one result
// beat through the command queue and the result register. Input beats are
// decoded and queued in a two-entry command queue; the back end retires one
// command per cycle while results are taken. A stall on the result side fills
// the queue before the input side is held. Input is also held off in the cycle
// that reset is released.
module core_local_timer_interruptor import clint_pkg::*; #(
  parameter int HART_COUNT = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // bus_address, access_wide, write_data, zero pad
  input  logic [1:0]             in_tuser,  // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // read_data, timer_pending, soft_pending, zero pad
  output logic                   out_tuser  // access_error
);

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_out;

  clint_front #(.HART_COUNT(HART_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  clint_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .cmd_valid (q_valid),
    .cmd       (q_out)
  );

  clint_back #(.HART_COUNT(HART_COUNT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd        (q_out),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: sv/clint_front.sv
// ----------------------------------------------------------------------------
// Core-local timer interruptor: front end
// Takes input beats and decodes operation, target, hart and access error.
// ----------------------------------------------------------------------------
module clint_front import clint_pkg::*; #(
  parameter int HART_COUNT = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  localparam logic [15:0] SOFT_END = 16'(int'(SOFT_BASE) + SOFT_STEP * HART_COUNT);
  localparam logic [15:0] CMP_END  = 16'(int'(CMP_BASE) + CMP_STEP * HART_COUNT);
  localparam logic [15:0] TIME_END = 16'(int'(TIME_ADDR) + 8);

  logic [15:0] addr;
  logic        wide;
  logic [15:0] cmp_off;
  logic        off_ok;
  logic        rw;
  logic        busy_r;

  assign addr    = in_tdata[15:0];
  assign wide    = in_tdata[16];
  assign cmp_off = addr - CMP_BASE;
  assign off_ok  = wide ? (addr[2:0] == 3'd0) : (addr[1:0] == 2'd0);
  assign rw      = (op_t'(in_tuser) == OP_READ) || (op_t'(in_tuser) == OP_WRITE);

  assign in_tready = !q_full && busy_r;
  assign q_push    = in_tvalid && in_tready;

  // holds off input for the cycle that reset is released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= 1'b1;
    end
  end

  always_comb begin
    q_cmd        = '0;
    q_cmd.op     = op_t'(in_tuser);
    q_cmd.wide   = wide;
    q_cmd.hi     = addr[2];
    q_cmd.data   = in_tdata[80:17];
    q_cmd.target = TGT_NONE;
    if (addr < SOFT_END) begin
      q_cmd.target = TGT_SOFT;
      q_cmd.hart   = HART_IDX_W'((addr - SOFT_BASE) >> 2);
      q_cmd.err    = wide || (addr[1:0] != 2'd0);
    end else if (addr >= CMP_BASE && addr < CMP_END) begin
      q_cmd.target = TGT_CMP;
      q_cmd.hart   = HART_IDX_W'(cmp_off >> 3);
      q_cmd.err    = !off_ok;
    end else if (addr >= TIME_ADDR && addr < TIME_END) begin
      q_cmd.target = TGT_TIME;
      q_cmd.err    = !off_ok;
    end else begin
      q_cmd.err    = 1'b1;
    end
    if (!rw) begin
      q_cmd.err = 1'b0;
    end
  end

endmodule

// File: sv/clint_queue.sv
// ----------------------------------------------------------------------------
// Core-local timer interruptor: command queue
// Short FIFO of decoded commands between front and back ends.
// ----------------------------------------------------------------------------
module clint_queue import clint_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic cmd_valid,
  output cmd_t cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t        q_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;

  assign full      = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/clint_back.sv
// ----------------------------------------------------------------------------
// Core-local timer interruptor: back end
// Holds time, compare and soft bits, executes commands, drives result beats.
// ----------------------------------------------------------------------------
module clint_back import clint_pkg::*; #(
  parameter int HART_COUNT = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  localparam int HW = (HART_COUNT > 1) ? $clog2(HART_COUNT) : 1;

  logic [63:0]           time_r, time_nxt;
  logic [63:0]           cmp_r   [HART_COUNT];
  logic [63:0]           cmp_nxt [HART_COUNT];
  logic [HART_COUNT-1:0] soft_r, soft_nxt;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                  out_err_r;
  logic                  fire;
  logic [HW-1:0]         hsel;
  logic [63:0]           rd;
  logic [1:0]            tp;
  logic [1:0]            sp;

  assign fire       = cmd_valid && (!out_valid_r || out_tready);
  assign pop        = fire;
  assign hsel       = cmd.hart[HW-1:0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  always_comb begin
    time_nxt = time_r;
    cmp_nxt  = cmp_r;
    soft_nxt = soft_r;
    rd       = '0;
    if (fire && !cmd.err) begin
      case (cmd.op)
        OP_TICK: begin
          time_nxt = time_r + 64'd1;
        end
        OP_READ: begin
          case (cmd.target)
            TGT_SOFT: rd = {63'd0, soft_r[hsel]};
            TGT_CMP:  rd = half_read(cmp_r[hsel], cmd.wide, cmd.hi);
            TGT_TIME: rd = half_read(time_r, cmd.wide, cmd.hi);
            default:  rd = '0;
          endcase
        end
        OP_WRITE: begin
          case (cmd.target)
            TGT_SOFT: soft_nxt[hsel] = cmd.data[0];
            TGT_CMP:  cmp_nxt[hsel]  = half_merge(cmp_r[hsel], cmd.data, cmd.wide, cmd.hi);
            TGT_TIME: time_nxt       = half_merge(time_r, cmd.data, cmd.wide, cmd.hi);
            default:  ;
          endcase
        end
        default: ;
      endcase
    end
  end

  for (genvar h = 0; h < 2; h++) begin : g_pend
    if (h < HART_COUNT) begin : g_on
      assign tp[h] = (time_nxt >= cmp_nxt[h]);
      assign sp[h] = soft_nxt[h];
    end else begin : g_off
      assign tp[h] = 1'b0;
      assign sp[h] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      soft_r      <= '0;
      out_valid_r <= 1'b0;
      for (int h = 0; h < HART_COUNT; h++) begin
        cmp_r[h] <= '1;
      end
    end else begin
      time_r <= time_nxt;
      soft_r <= soft_nxt;
      cmp_r  <= cmp_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {4'd0, sp, tp, rd};
      out_err_r  <= cmd.err;
    end
  end

endmodule

// File: sv/clint_chk.sv
// ----------------------------------------------------------------------------
// Core-local timer interruptor: port checker
// Watches the top-level ports; bound to every instance of the top level.
// ----------------------------------------------------------------------------
`include "core_local_timer_interruptor_assert.svh"

module clint_chk import clint_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  `CLINT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `CLINT_ASSERT_IMPL(a_err_reads_zero, out_tvalid && out_tuser, out_tdata[63:0] == 64'd0)
  `CLINT_ASSERT_IMPL(a_in_held_only_on_stall, !in_tready && $past(rst_n), $past(out_tvalid && !out_tready))

endmodule

bind core_local_timer_interruptor clint_chk u_clint_chk (.*);

// File: verif/core_local_timer_interruptor_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Core-local timer interruptor: testbench scoreboard
// Keeps its own copy of the time counter, compares and soft bits, works out
// the result of every accepted input beat and checks result beats in order.
// ----------------------------------------------------------------------------
package core_local_timer_interruptor_tb_pkg;
  import clint_pkg::*;

  typedef struct {
    logic [63:0] rdata;
    logic        err;
    logic [1:0]  tpend;
    logic [1:0]  spend;
  } clint_result_t;

  class clint_scoreboard;
    int unsigned   harts;
    logic [63:0]   mtime;
    logic [63:0]   mtimecmp[];
    logic          msip[];
    clint_result_t results_due[$];
    int unsigned   mismatches;

    function new(int unsigned n);
      harts      = n;
      mtimecmp   = new[n];
      msip       = new[n];
      mtime      = '0;
      mismatches = 0;
      foreach (mtimecmp[i]) begin
        mtimecmp[i] = '1;
        msip[i]     = 1'b0;
      end
    endfunction

    // 64-bit register seen through 32- or 64-bit accesses
    function bit access_dword(inout logic [63:0] r, input int unsigned off, input logic wide,
                              input bit wr, input logic [63:0] wd, output logic [63:0] rd);
      rd = '0;
      if (wide) begin
        if (off != 0) return 0;
        if (wr) r = wd;
        else rd = r;
        return 1;
      end
      if (off == 0) begin
        if (wr) r[31:0] = wd[31:0];
        else rd = {32'd0, r[31:0]};
        return 1;
      end
      if (off == 4) begin
        if (wr) r[63:32] = wd[31:0];
        else rd = {32'd0, r[63:32]};
        return 1;
      end
      return 0;
    endfunction

    function void note_beat(op_t op, logic [15:0] addr, logic wide, logic [63:0] wd);
      clint_result_t r;
      int unsigned   a;
      int unsigned   h;
      bit            ok;
      bit            wr;
      logic [63:0]   rd;
      a  = addr;
      ok = 1;
      rd = '0;
      wr = (op == OP_WRITE);
      case (op)
        OP_TICK: begin
          mtime = mtime + 64'd1;
        end
        OP_READ, OP_WRITE: begin
          if (a < SOFT_BASE + SOFT_STEP * harts) begin
            h  = a / SOFT_STEP;
            ok = !wide && (a % SOFT_STEP == 0);
            if (ok) begin
              if (wr) msip[h] = wd[0];
              else rd = {63'd0, msip[h]};
            end
          end else if (a >= CMP_BASE && a < CMP_BASE + CMP_STEP * harts) begin
            h  = (a - CMP_BASE) / CMP_STEP;
            ok = access_dword(mtimecmp[h], (a - CMP_BASE) % CMP_STEP, wide, wr, wd, rd);
          end else if (a >= TIME_ADDR && a < TIME_ADDR + 8) begin
            ok = access_dword(mtime, a - TIME_ADDR, wide, wr, wd, rd);
          end else begin
            ok = 0;
          end
        end
        default: ;
      endcase
      r.rdata = ok ? rd : 64'd0;
      r.err   = !ok;
      r.tpend = '0;
      r.spend = '0;
      for (int i = 0; i < harts && i < 2; i++) begin
        r.tpend[i] = (mtime >= mtimecmp[i]);
        r.spend[i] = msip[i];
      end
      results_due.push_back(r);
    endfunction

    function void check_beat(logic [63:0] rdata, logic err, logic [1:0] tpend,
                             logic [1:0] spend);
      clint_result_t e;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing due: rdata=%h err=%b tp=%b sp=%b",
                   $realtime, rdata, err, tpend, spend);
        return;
      end
      e = results_due.pop_front();
      if (rdata !== e.rdata || err !== e.err || tpend !== e.tpend || spend !== e.spend) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp rdata=%h err=%b tp=%b sp=%b, got rdata=%h err=%b tp=%b sp=%b",
                   $realtime, e.rdata, e.err, e.tpend, e.spend, rdata, err, tpend, spend);
      end
    endfunction

    function int unsigned outstanding();
      return results_due.size();
    endfunction
  endclass

endpackage

// File: verif/core_local_timer_interruptor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Core-local timer interruptor: testbench top
// Directed register accesses and ticks, then a biased random mix of timer
// set-ups, register traffic and malformed accesses, with random idling on both
// streams. Every result beat is checked against the scoreboard.
// ----------------------------------------------------------------------------
module core_local_timer_interruptor_tb;
  import clint_pkg::*;
  import core_local_timer_interruptor_tb_pkg::*;

  localparam int HARTS     = 2;
  localparam int N_BEATS   = 2000;
  localparam int CALM_FROM = 1700;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // bus_address, access_wide, write_data, zero pad
  logic [1:0]             in_tuser   = '0;  // operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // read_data, timer_pending, soft_pending, zero pad
  logic                   out_tuser;        // access_error

  clint_scoreboard sb = new(HARTS);
  bit              no_idle = 1'b0;
  int              stall_left = 0;
  int              beats_sent = 0;

  core_local_timer_interruptor #(.HART_COUNT(HARTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("core_local_timer_interruptor_tb: errors");
    $finish;
  end

  always @(negedge clk) begin
    if (no_idle || !rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_beat(out_tdata[63:0], out_tuser, out_tdata[65:64], out_tdata[67:66]);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(op_t op, logic [15:0] addr, logic wide, logic [63:0] wd);
    int n;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W-81){1'b0}}, wd, wide, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_beat(op, addr, wide, wd);
    if (op != OP_NOP) beats_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] mapped_addr(logic wide);
    int unsigned h;
    h = $urandom_range(0, HARTS - 1);
    if (wide)
      return ($urandom_range(0, 2) == 0) ? TIME_ADDR : 16'(CMP_BASE + CMP_STEP * h);
    case ($urandom_range(0, 2))
      0:       return 16'(SOFT_BASE + SOFT_STEP * h);
      1:       return 16'(CMP_BASE + CMP_STEP * h + 4 * $urandom_range(0, 1));
      default: return 16'(TIME_ADDR + 4 * $urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return {$urandom, $urandom};
      1:       return 64'($urandom_range(0, 1000));
      2:       return ~64'd0 - 64'($urandom_range(0, 20));
      default: return sb.mtime + 64'($urandom_range(0, 16));
    endcase
  endfunction

  initial begin
    int unsigned kind;
    int unsigned h;
    logic        w;
    logic [63:0] v;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values
    send_beat(OP_READ,  TIME_ADDR,        1'b1, '0);
    send_beat(OP_READ,  CMP_BASE,         1'b1, '0);
    send_beat(OP_READ,  CMP_BASE + 16'd8, 1'b0, '0);
    send_beat(OP_READ,  CMP_BASE + 16'hC, 1'b0, '0);
    // soft bits keep bit 0 only
    send_beat(OP_WRITE, SOFT_BASE,        1'b0, '1);
    send_beat(OP_WRITE, SOFT_BASE + 16'd4, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_beat(OP_WRITE, SOFT_BASE + 16'd4, 1'b0, 64'd1);
    send_beat(OP_READ,  SOFT_BASE + 16'd4, 1'b0, '0);
    // illegal soft accesses
    send_beat(OP_READ,  SOFT_BASE,        1'b1, '0);
    send_beat(OP_READ,  16'h0002,         1'b0, '0);
    send_beat(OP_WRITE, 16'h0008,         1'b0, '1);
    // compare halves, then pending after ticks
    send_beat(OP_WRITE, CMP_BASE,         1'b0, 64'hFFFF_FFFF_0000_0000);
    send_beat(OP_WRITE, CMP_BASE + 16'd4, 1'b0, 64'd0);
    send_beat(OP_WRITE, CMP_BASE + 16'd8, 1'b1, 64'd3);
    repeat (3) send_beat(OP_TICK, '1, 1'b1, '1);
    send_beat(OP_WRITE, CMP_BASE + 16'h10, 1'b0, '0);
    send_beat(OP_READ,  CMP_BASE + 16'd4, 1'b1, '0);
    // time counter wrap
    send_beat(OP_WRITE, TIME_ADDR,        1'b1, '1);
    send_beat(OP_TICK,  '0,               1'b0, '0);
    send_beat(OP_READ,  TIME_ADDR + 16'd4, 1'b1, '0);
    send_beat(OP_READ,  TIME_ADDR + 16'd4, 1'b0, '0);
    send_beat(OP_WRITE, 16'hFFFF,         1'b1, '1);
    send_beat(OP_NOP,   TIME_ADDR,        1'b1, '1);
    send_beat(OP_WRITE, TIME_ADDR,        1'b0, '1);

    while (beats_sent < N_BEATS) begin
      if (beats_sent >= CALM_FROM) no_idle = 1'b1;
      kind = $urandom_range(0, 99);
      h    = $urandom_range(0, HARTS - 1);
      w    = 1'($urandom);
      if (kind < 35) begin
        send_beat(OP_TICK, 16'($urandom), w, {$urandom, $urandom});
      end else if (kind < 45) begin
        // arm a compare just ahead of the counter
        v = sb.mtime + 64'($urandom_range(0, 12));
        if (w) begin
          send_beat(OP_READ,  16'(CMP_BASE + CMP_STEP * h), 1'b1, {$urandom, $urandom});
          send_beat(OP_WRITE, 16'(CMP_BASE + CMP_STEP * h), 1'b1, v);
        end else begin
          send_beat(OP_WRITE, 16'(CMP_BASE + CMP_STEP * h), 1'b0, {$urandom, v[31:0]});
          send_beat(OP_WRITE, 16'(CMP_BASE + CMP_STEP * h + 4), 1'b0, {$urandom, v[63:32]});
        end
      end else if (kind < 60) begin
        send_beat(OP_READ, mapped_addr(w), w, {$urandom, $urandom});
      end else if (kind < 75) begin
        send_beat(OP_WRITE, mapped_addr(w), w, pick_value());
      end else if (kind < 80) begin
        v = w ? {$urandom, $urandom} : ~64'd0 - 64'($urandom_range(0, 8));
        send_beat(OP_WRITE, TIME_ADDR, 1'b1, v);
      end else if (kind < 92) begin
        send_beat($urandom_range(0, 1) ? OP_WRITE : OP_READ, 16'($urandom), w, pick_value());
      end else if (kind < 95) begin
        send_beat(OP_NOP, 16'($urandom), w, {$urandom, $urandom});
      end else begin
        // near misses around the mapped registers
        case ($urandom_range(0, 2))
          0:       v = 64'(mapped_addr(w) + $urandom_range(1, 3));
          1:       v = 64'(CMP_BASE + CMP_STEP * HARTS + 4 * $urandom_range(0, 1));
          default: v = 64'(SOFT_BASE + SOFT_STEP * HARTS);
        endcase
        send_beat($urandom_range(0, 1) ? OP_WRITE : OP_READ, v[15:0], w, pick_value());
      end
    end

    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("core_local_timer_interruptor_tb: clean");
    end else begin
      $display("core_local_timer_interruptor_tb: errors");
    end
    $finish;
  end

endmodule
